@@ rtl/i2c_register_access_master_core_macros.svh @@
// Assertion macros for the I2C register access master RTL, used by i2cram_engine.
// Used by files that include this header; expects clk and rst in scope.
`ifndef I2C_REGISTER_ACCESS_MASTER_CORE_MACROS_SVH
`define I2C_REGISTER_ACCESS_MASTER_CORE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define I2CRAM_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("i2c master check failed");

// Condition that must never hold outside reset.
`define I2CRAM_NEVER(lbl, cond) \
  `I2CRAM_CHECK(lbl, !(cond))

`endif

@@ rtl/i2cram_pkg.sv @@
// Package for the I2C register access master: codes, sizes and the
// request and result types shared by the front, engine and queues.
package i2cram_pkg;

  // Queue sizing between the stages
  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  // Burst limit and reset values of the configuration registers
  localparam logic [8:0]  MAX_BURST       = 9'd256;
  localparam logic [6:0]  RST_DEV_ADDR    = 7'h34;
  localparam logic [15:0] RST_PHASE_TICKS = 16'd16;

  // Request types
  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_SINGLE = 2'd1;
  localparam logic [1:0] REQ_BURST  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_PHASE_TICKS    = 1'b1;

  // Bus sequencer steps
  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_START1   = 4'd1,
    ST_ADDR_W   = 4'd2,
    ST_REG      = 4'd3,
    ST_DATA     = 4'd4,
    ST_STOP_MID = 4'd5,
    ST_START2   = 4'd6,
    ST_ADDR_R   = 4'd7,
    ST_RECV     = 4'd8,
    ST_STOP_END = 4'd9
  } step_t;

  // Classified tick request from the front
  typedef struct packed {
    logic       start;
    logic [1:0] req_type;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [8:0] bytes_init;
    logic       sda_in;
  } item_t;

  // Per-tick result from the engine
  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_last;
    logic       done_res;
    logic       status;
  } res_t;

endpackage

@@ rtl/i2c_register_access_master_core.sv @@
// I2C register access master. Each request is one bus-timer tick carrying
// the sampled SDA level and an optional write, single-read or burst-read
// command; each tick yields exactly one result with the SCL/SDA drive, busy,
// received byte and done/status flags. One request is taken per cycle while
// neither queue is full; a request is registered in the front queue, then the
// sequencer step and result queue write happen at one edge, after which the
// result is on the result ports and can be popped. The bus sequencer advances
// its state once per tick taken. Two-entry queues on each side let the
// producer and consumer stall independently.
// Depends on i2cram_pkg, i2cram_front, i2cram_engine and i2cram_resq.
module i2c_register_access_master_core import i2cram_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        push,
  output logic        full,
  input  logic        cmd_valid,
  input  logic [1:0]  req_type,
  input  logic [7:0]  reg_addr,
  input  logic [7:0]  write_data,
  input  logic [8:0]  byte_count,
  input  logic        sda_in,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic        scl_level,
  output logic        sda_pull_low,
  output logic        busy_res,
  output logic        read_valid,
  output logic [7:0]  read_data,
  output logic        read_last,
  output logic        done_res,
  output logic        status,
  // configuration
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  item_t q_item;
  logic  q_empty;
  logic  q_pop;
  res_t  eng_res;
  logic  eng_push;
  logic  rq_full;
  res_t  out_res;

  // Request decode and queue
  i2cram_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd_valid  (cmd_valid),
    .req_type   (req_type),
    .reg_addr   (reg_addr),
    .write_data (write_data),
    .byte_count (byte_count),
    .sda_in     (sda_in),
    .q_item     (q_item),
    .q_empty    (q_empty),
    .q_pop      (q_pop)
  );

  // Bus sequencer
  i2cram_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item       (q_item),
    .item_valid (!q_empty),
    .item_pop   (q_pop),
    .res_full   (rq_full),
    .res        (eng_res),
    .res_push   (eng_push)
  );

  // Result queue
  i2cram_resq u_resq (
    .clk       (clk),
    .rst       (rst),
    .in_res    (eng_res),
    .in_push   (eng_push),
    .in_full   (rq_full),
    .out_res   (out_res),
    .out_empty (empty),
    .out_pop   (pop)
  );

  assign scl_level    = out_res.scl_level;
  assign sda_pull_low = out_res.sda_pull_low;
  assign busy_res     = out_res.busy_res;
  assign read_valid   = out_res.read_valid;
  assign read_data    = out_res.read_data;
  assign read_last    = out_res.read_last;
  assign done_res     = out_res.done_res;
  assign status       = out_res.status;

endmodule

@@ rtl/i2cram_front.sv @@
// Front stage: decodes each tick request and queues it for the engine.
// Depends on i2cram_pkg.
module i2cram_front import i2cram_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       cmd_valid,
  input  logic [1:0] req_type,
  input  logic [7:0] reg_addr,
  input  logic [7:0] write_data,
  input  logic [8:0] byte_count,
  input  logic       sda_in,
  output item_t      q_item,
  output logic       q_empty,
  input  logic       q_pop
);

  item_t            dec;
  logic [8:0]       cnt;
  item_t            mem [QDEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             wr_ok;
  logic             rd_ok;

  // Classify the command and size the read
  always_comb begin
    cnt = byte_count;
    if (cnt == 9'd0) begin
      cnt = 9'd1;
    end else if (cnt > MAX_BURST) begin
      cnt = MAX_BURST;
    end
    dec.start      = cmd_valid && (req_type inside {REQ_WRITE, REQ_SINGLE, REQ_BURST});
    dec.req_type   = req_type;
    dec.reg_addr   = reg_addr;
    dec.write_data = write_data;
    case (req_type)
      REQ_WRITE:  dec.bytes_init = 9'd0;
      REQ_SINGLE: dec.bytes_init = 9'd1;
      default:    dec.bytes_init = cnt;
    endcase
    dec.sda_in     = sda_in;
  end

  assign full    = (count == CNT_W'(QDEPTH));
  assign q_empty = (count == '0);
  assign wr_ok   = push && !full;
  assign rd_ok   = q_pop && !q_empty;
  assign q_item  = mem[rptr];

  // Request storage
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wptr] <= dec;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_ok) begin
        wptr <= PTR_W'(wptr + 1'b1);
      end
      if (rd_ok) begin
        rptr <= PTR_W'(rptr + 1'b1);
      end
      count <= CNT_W'(count + CNT_W'(wr_ok) - CNT_W'(rd_ok));
    end
  end

endmodule

@@ rtl/i2cram_engine.sv @@
// Back stage: the bus sequencer, one tick per request, plus the
// configuration registers. Depends on i2cram_pkg and the macro header.
`include "i2c_register_access_master_core_macros.svh"

module i2cram_engine import i2cram_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  item_t       item,
  input  logic        item_valid,
  output logic        item_pop,
  input  logic        res_full,
  output res_t        res,
  output logic        res_push
);

  logic [6:0]  device_address;
  logic [15:0] phase_ticks;

  step_t       step, step_next;
  logic [15:0] phase_counter, phase_counter_next;
  logic [1:0]  quarter_phase, quarter_phase_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [8:0]  bytes_left, bytes_left_next;
  logic [1:0]  latched_type, latched_type_next;
  logic [7:0]  latched_register, latched_register_next;
  logic [7:0]  latched_data, latched_data_next;
  logic        ack_failed, ack_failed_next;

  logic        fire;
  logic [15:0] pt;
  logic        last_tick;
  logic        is_send;

  assign fire     = item_valid && !res_full;
  assign item_pop = fire;
  assign res_push = fire;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= RST_DEV_ADDR;
      phase_ticks    <= RST_PHASE_TICKS;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS: device_address <= cfg_data[6:0];
        CFG_PHASE_TICKS:    phase_ticks    <= cfg_data;
        default:            phase_ticks    <= phase_ticks;
      endcase
    end
  end

  assign pt        = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
  assign last_tick = ({1'b0, phase_counter} + 17'd1) >= {1'b0, pt};
  assign is_send   = step inside {ST_ADDR_W, ST_REG, ST_DATA, ST_ADDR_R};

  // Sequencer: next state and pin levels
  always_comb begin
    logic [8:0] bl;
    bl                    = bytes_left;
    step_next             = step;
    phase_counter_next    = phase_counter;
    quarter_phase_next    = quarter_phase;
    bit_index_next        = bit_index;
    shift_byte_next       = shift_byte;
    bytes_left_next       = bytes_left;
    latched_type_next     = latched_type;
    latched_register_next = latched_register;
    latched_data_next     = latched_data;
    ack_failed_next       = ack_failed;
    res                   = '0;
    res.scl_level         = 1'b1;

    if (step == ST_IDLE) begin
      // Latch a new command; this tick only shows the idle bus
      if (item.start) begin
        latched_type_next     = item.req_type;
        latched_register_next = item.reg_addr;
        latched_data_next     = item.write_data;
        bytes_left_next       = item.bytes_init;
        ack_failed_next       = 1'b0;
        phase_counter_next    = '0;
        quarter_phase_next    = '0;
        bit_index_next        = '0;
        shift_byte_next       = '0;
        step_next             = ST_START1;
      end
    end else begin
      // Pin levels for the current quarter
      case (step)
        ST_START1, ST_START2: begin
          res.scl_level    = (quarter_phase == 2'd0) || (quarter_phase == 2'd1);
          res.sda_pull_low = (quarter_phase != 2'd0);
        end
        ST_STOP_MID, ST_STOP_END: begin
          res.scl_level    = (quarter_phase != 2'd0);
          res.sda_pull_low = (quarter_phase == 2'd0) || (quarter_phase == 2'd1);
        end
        default: begin
          res.scl_level = (quarter_phase == 2'd1) || (quarter_phase == 2'd2);
          if (is_send) begin
            res.sda_pull_low = (bit_index < 4'd8) ?
                               !shift_byte[3'(3'd7 - bit_index[2:0])] : 1'b0;
          end else begin
            res.sda_pull_low = (bit_index == 4'd8) && (bytes_left > 9'd1);
          end
        end
      endcase

      // Sample SDA at the end of the third quarter
      if (last_tick && quarter_phase == 2'd2) begin
        if (is_send && bit_index == 4'd8) begin
          if (item.sda_in) begin
            ack_failed_next = 1'b1;
          end
        end else if (step == ST_RECV && bit_index < 4'd8) begin
          shift_byte_next = {shift_byte[6:0], item.sda_in};
          if (bit_index == 4'd7) begin
            res.read_valid = 1'b1;
            res.read_data  = {shift_byte[6:0], item.sda_in};
            res.read_last  = (bytes_left <= 9'd1);
          end
        end
      end

      // Quarter timer and end of each bus element
      if (last_tick) begin
        phase_counter_next = '0;
        if (quarter_phase == 2'd3) begin
          quarter_phase_next = '0;
          case (step)
            ST_START1: begin
              step_next       = ST_ADDR_W;
              shift_byte_next = {device_address, 1'b0};
              bit_index_next  = '0;
            end
            ST_START2: begin
              step_next       = ST_ADDR_R;
              shift_byte_next = {device_address, 1'b1};
              bit_index_next  = '0;
            end
            ST_STOP_MID: step_next = ST_START2;
            ST_STOP_END: begin
              res.done_res = 1'b1;
              res.status   = ack_failed;
              step_next    = ST_IDLE;
            end
            default: begin
              if (bit_index < 4'd8) begin
                bit_index_next = bit_index + 4'd1;
              end else if (step == ST_RECV) begin
                if (bytes_left != 9'd0) begin
                  bl = bytes_left - 9'd1;
                end
                bytes_left_next = bl;
                if (bl == 9'd0) begin
                  step_next = ST_STOP_END;
                end else begin
                  shift_byte_next = '0;
                  bit_index_next  = '0;
                end
              end else if (ack_failed) begin
                step_next = ST_STOP_END;
              end else begin
                case (step)
                  ST_ADDR_W: begin
                    step_next       = ST_REG;
                    shift_byte_next = latched_register;
                    bit_index_next  = '0;
                  end
                  ST_REG: begin
                    if (latched_type == REQ_WRITE) begin
                      step_next       = ST_DATA;
                      shift_byte_next = latched_data;
                      bit_index_next  = '0;
                    end else begin
                      step_next = ST_STOP_MID;
                    end
                  end
                  ST_ADDR_R: begin
                    step_next       = ST_RECV;
                    shift_byte_next = '0;
                    bit_index_next  = '0;
                  end
                  default: step_next = ST_STOP_END;
                endcase
              end
            end
          endcase
        end else begin
          quarter_phase_next = quarter_phase + 2'd1;
        end
      end else begin
        phase_counter_next = phase_counter + 16'd1;
      end
    end

    res.busy_res = (step_next != ST_IDLE);
  end

  // Sequencer state, advanced once per tick taken
  always_ff @(posedge clk) begin
    if (rst) begin
      step             <= ST_IDLE;
      phase_counter    <= '0;
      quarter_phase    <= '0;
      bit_index        <= '0;
      shift_byte       <= '0;
      bytes_left       <= '0;
      latched_type     <= '0;
      latched_register <= '0;
      latched_data     <= '0;
      ack_failed       <= 1'b0;
    end else if (fire) begin
      step             <= step_next;
      phase_counter    <= phase_counter_next;
      quarter_phase    <= quarter_phase_next;
      bit_index        <= bit_index_next;
      shift_byte       <= shift_byte_next;
      bytes_left       <= bytes_left_next;
      latched_type     <= latched_type_next;
      latched_register <= latched_register_next;
      latched_data     <= latched_data_next;
      ack_failed       <= ack_failed_next;
    end
  end

  // Checks
  `I2CRAM_NEVER(a_rvalid_outside_recv, fire && res.read_valid && step != ST_RECV)
  `I2CRAM_NEVER(a_done_while_busy, fire && res.done_res && res.busy_res)
  `I2CRAM_CHECK(a_start_begins, fire && step == ST_IDLE && item.start |=> step == ST_START1)
  `I2CRAM_NEVER(a_bit_overrun, bit_index > 4'd8)

endmodule

@@ rtl/i2cram_resq.sv @@
// Result queue: holds per-tick results until the consumer pops them.
// Depends on i2cram_pkg.
module i2cram_resq import i2cram_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  res_t in_res,
  input  logic in_push,
  output logic in_full,
  output res_t out_res,
  output logic out_empty,
  input  logic out_pop
);

  res_t             mem [QDEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             wr_ok;
  logic             rd_ok;

  assign in_full   = (count == CNT_W'(QDEPTH));
  assign out_empty = (count == '0);
  assign wr_ok     = in_push && !in_full;
  assign rd_ok     = out_pop && !out_empty;
  assign out_res   = mem[rptr];

  // Result storage
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wptr] <= in_res;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_ok) begin
        wptr <= PTR_W'(wptr + 1'b1);
      end
      if (rd_ok) begin
        rptr <= PTR_W'(rptr + 1'b1);
      end
      count <= CNT_W'(count + CNT_W'(wr_ok) - CNT_W'(rd_ok));
    end
  end

endmodule

@@ tb/i2c_register_access_master_core_tb.sv @@
// Testbench for i2c_register_access_master_core: drives bus-timer tick requests,
// plays an acknowledging or refusing device on SDA and checks every tick result.
// Depends on i2cram_pkg and the RTL of the core only.
`timescale 1ns / 100ps

module i2c_register_access_master_core_tb;
  import i2cram_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  // One tick request as it goes into the core
  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] req_type;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [8:0] byte_count;
    logic       sda_in;
  } tick_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        cmd_valid = 1'b0;
  logic [1:0]  req_type = REQ_WRITE;
  logic [7:0]  reg_addr = 8'h00;
  logic [7:0]  write_data = 8'h00;
  logic [8:0]  byte_count = 9'd0;
  logic        sda_in = 1'b1;
  logic        empty;
  logic        pop = 1'b0;
  logic        scl_level;
  logic        sda_pull_low;
  logic        busy_res;
  logic        read_valid;
  logic [7:0]  read_data;
  logic        read_last;
  logic        done_res;
  logic        status;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_DEVICE_ADDRESS;
  logic [15:0] cfg_data = 16'd0;

  i2c_register_access_master_core dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .cmd_valid(cmd_valid), .req_type(req_type), .reg_addr(reg_addr),
    .write_data(write_data), .byte_count(byte_count), .sda_in(sda_in),
    .empty(empty), .pop(pop),
    .scl_level(scl_level), .sda_pull_low(sda_pull_low), .busy_res(busy_res),
    .read_valid(read_valid), .read_data(read_data), .read_last(read_last),
    .done_res(done_res), .status(status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Bus sequencer mirror and its configuration
  step_t       bus_step = ST_IDLE;
  logic [15:0] tick_in_quarter = '0;
  logic [1:0]  quarter = '0;
  logic [3:0]  bit_pos = '0;
  logic [7:0]  shift_reg = '0;
  logic [8:0]  bytes_to_read = '0;
  logic [1:0]  cmd_kind = '0;
  logic [7:0]  cmd_reg = '0;
  logic [7:0]  cmd_data = '0;
  logic        nack_seen = 1'b0;
  logic [6:0]  dev_addr = RST_DEV_ADDR;
  logic [15:0] quarter_len = RST_PHASE_TICKS;

  res_t        bus_tick_q[$];
  res_t        head_tick;
  int unsigned fail_count = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;
  int unsigned cycle_count = 0;
  logic [7:0]  pop_pattern = 8'hFF;
  int unsigned pattern_age = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit sends_byte(input step_t s);
    return (s == ST_ADDR_W) || (s == ST_REG) || (s == ST_DATA) || (s == ST_ADDR_R);
  endfunction

  // Advance the bus sequencer by one tick and return the pins and flags it shows
  function automatic res_t advance_bus(input tick_t t);
    res_t       r;
    logic [8:0] cnt;
    logic [15:0] len;
    logic       last_tick;
    logic       finished;
    r = '0;
    r.scl_level = 1'b1;
    finished = 1'b0;
    if (bus_step == ST_IDLE) begin
      if (t.cmd_valid && t.req_type != REQ_UNKNOWN) begin
        cnt = (t.byte_count == 9'd0) ? 9'd1 : t.byte_count;
        if (cnt > MAX_BURST) cnt = MAX_BURST;
        cmd_kind = t.req_type;
        cmd_reg = t.reg_addr;
        cmd_data = t.write_data;
        bytes_to_read = (t.req_type == REQ_WRITE) ? 9'd0 :
                        (t.req_type == REQ_SINGLE) ? 9'd1 : cnt;
        nack_seen = 1'b0;
        tick_in_quarter = '0;
        quarter = '0;
        bit_pos = '0;
        shift_reg = '0;
        bus_step = ST_START1;
      end
    end else begin
      len = (quarter_len == 16'd0) ? 16'd1 : quarter_len;
      // pins for the current quarter
      case (bus_step)
        ST_START1, ST_START2: begin
          r.scl_level = (quarter <= 2'd1);
          r.sda_pull_low = (quarter != 2'd0);
        end
        ST_STOP_MID, ST_STOP_END: begin
          r.scl_level = (quarter != 2'd0);
          r.sda_pull_low = (quarter <= 2'd1);
        end
        default: begin
          r.scl_level = (quarter == 2'd1) || (quarter == 2'd2);
          if (sends_byte(bus_step))
            r.sda_pull_low = (bit_pos < 4'd8) ? !shift_reg[3'd7 - bit_pos[2:0]] : 1'b0;
          else
            r.sda_pull_low = (bit_pos == 4'd8) && (bytes_to_read > 9'd1);
        end
      endcase
      // SDA is sampled at the end of the third quarter
      last_tick = ({1'b0, tick_in_quarter} + 17'd1) >= {1'b0, len};
      if (last_tick && quarter == 2'd2) begin
        if (sends_byte(bus_step) && bit_pos == 4'd8) begin
          if (t.sda_in) nack_seen = 1'b1;
        end else if (bus_step == ST_RECV && bit_pos < 4'd8) begin
          shift_reg = {shift_reg[6:0], t.sda_in};
          if (bit_pos == 4'd7) begin
            r.read_valid = 1'b1;
            r.read_data = shift_reg;
            r.read_last = (bytes_to_read <= 9'd1);
          end
        end
      end
      if (!last_tick) begin
        tick_in_quarter++;
      end else begin
        tick_in_quarter = '0;
        if (quarter != 2'd3) begin
          quarter++;
        end else begin
          // end of one bus element
          quarter = '0;
          case (bus_step)
            ST_START1: begin
              bus_step = ST_ADDR_W;
              shift_reg = {dev_addr, 1'b0};
              bit_pos = '0;
            end
            ST_START2: begin
              bus_step = ST_ADDR_R;
              shift_reg = {dev_addr, 1'b1};
              bit_pos = '0;
            end
            ST_STOP_MID: bus_step = ST_START2;
            ST_STOP_END: begin
              finished = 1'b1;
              bus_step = ST_IDLE;
            end
            default: begin
              if (bit_pos < 4'd8) begin
                bit_pos++;
              end else if (bus_step == ST_RECV) begin
                if (bytes_to_read != 9'd0) bytes_to_read--;
                if (bytes_to_read == 9'd0) begin
                  bus_step = ST_STOP_END;
                end else begin
                  shift_reg = '0;
                  bit_pos = '0;
                end
              end else if (nack_seen) begin
                bus_step = ST_STOP_END;
              end else begin
                case (bus_step)
                  ST_ADDR_W: begin
                    bus_step = ST_REG;
                    shift_reg = cmd_reg;
                    bit_pos = '0;
                  end
                  ST_REG: begin
                    if (cmd_kind == REQ_WRITE) begin
                      bus_step = ST_DATA;
                      shift_reg = cmd_data;
                      bit_pos = '0;
                    end else begin
                      bus_step = ST_STOP_MID;
                    end
                  end
                  ST_ADDR_R: begin
                    bus_step = ST_RECV;
                    shift_reg = '0;
                    bit_pos = '0;
                  end
                  default: bus_step = ST_STOP_END;
                endcase
              end
            end
          endcase
          if (finished) r.status = nack_seen;
        end
      end
    end
    r.busy_res = (bus_step != ST_IDLE);
    r.done_res = finished;
    return r;
  endfunction

  function automatic tick_t noise_tick();
    tick_t t;
    t.cmd_valid = 1'($urandom);
    t.req_type = 2'($urandom);
    t.reg_addr = 8'($urandom);
    t.write_data = 8'($urandom);
    t.byte_count = 9'($urandom);
    t.sda_in = 1'($urandom);
    return t;
  endfunction

  // Send one tick request in bursts with random gaps; record its outcome
  task automatic send_tick(input tick_t t);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    push <= 1'b1;
    cmd_valid <= t.cmd_valid;
    req_type <= t.req_type;
    reg_addr <= t.reg_addr;
    write_data <= t.write_data;
    byte_count <= t.byte_count;
    sda_in <= t.sda_in;
    do @(posedge clk); while (full);
    bus_tick_q.push_back(advance_bus(t));
  endtask

  // Register write once the core has drained
  task automatic set_register(input logic idx, input logic [15:0] val);
    push <= 1'b0;
    while (bus_tick_q.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_DEVICE_ADDRESS) dev_addr = val[6:0];
    else quarter_len = val;
    @(posedge clk);
  endtask

  // Idle ticks; any command among them carries the unknown type
  task automatic idle_ticks(input int unsigned n);
    tick_t t;
    repeat (n) begin
      t = noise_tick();
      if (t.cmd_valid) t.req_type = REQ_UNKNOWN;
      send_tick(t);
    end
  endtask

  // One transaction to its end; the device refuses the byte sent in nack_on.
  // rx_level < 0 gives random SDA, else SDA held at that level outside acks.
  task automatic run_transfer(input logic [1:0] kind, input logic [7:0] regn,
                              input logic [7:0] data, input logic [8:0] count,
                              input step_t nack_on, input int rx_level);
    tick_t t;
    t = noise_tick();
    t.cmd_valid = 1'b1;
    t.req_type = kind;
    t.reg_addr = regn;
    t.write_data = data;
    t.byte_count = count;
    send_tick(t);
    while (bus_step != ST_IDLE) begin
      t = noise_tick();
      if (sends_byte(bus_step) && bit_pos == 4'd8) t.sda_in = (bus_step == nack_on);
      else if (rx_level >= 0) t.sda_in = rx_level[0];
      send_tick(t);
    end
  endtask

  task automatic test_ignored_commands();
    tick_t t;
    idle_ticks(6);
    t = noise_tick();
    t.cmd_valid = 1'b1;
    t.req_type = REQ_UNKNOWN;
    send_tick(t);
    idle_ticks(3);
  endtask

  // Reset device address on a short refused transfer, one tick per quarter
  task automatic test_reset_settings();
    set_register(CFG_PHASE_TICKS, 16'd1);
    run_transfer(REQ_WRITE, 8'h3C, 8'hC3, 9'd1, ST_ADDR_W, -1);
  endtask

  task automatic test_writes();
    run_transfer(REQ_WRITE, 8'hA5, 8'h5A, 9'd511, ST_IDLE, -1);
  endtask

  task automatic test_single_reads();
    run_transfer(REQ_SINGLE, 8'h10, 8'h00, 9'd9, ST_IDLE, -1);
  endtask

  // Zero reads as one; a two-byte burst with no request gaps
  task automatic test_burst_lengths();
    run_transfer(REQ_BURST, 8'h20, 8'h00, 9'd0, ST_IDLE, 1);
    gaps_on = 1'b0;
    run_transfer(REQ_BURST, 8'h22, 8'h00, 9'd2, ST_IDLE, -1);
    gaps_on = 1'b1;
  endtask

  // Refused byte at later points of the transfer
  task automatic test_missing_ack();
    run_transfer(REQ_SINGLE, 8'h32, 8'h33, 9'd1, ST_REG, -1);
    run_transfer(REQ_BURST, 8'h36, 8'h37, 9'd4, ST_ADDR_R, -1);
  endtask

  task automatic test_register_extremes();
    // lowest address; zero quarter length runs as one tick
    set_register(CFG_DEVICE_ADDRESS, 16'd0);
    set_register(CFG_PHASE_TICKS, 16'd0);
    run_transfer(REQ_WRITE, 8'h55, 8'hAA, 9'd1, ST_ADDR_W, -1);
    set_register(CFG_DEVICE_ADDRESS, 16'h007F);
    set_register(CFG_PHASE_TICKS, 16'd2);
    run_transfer(REQ_SINGLE, 8'hAA, 8'h55, 9'd1, ST_ADDR_W, -1);
    set_register(CFG_PHASE_TICKS, 16'hFFFF);
    idle_ticks(5);
  endtask

  // Result side stalls on a rotating pattern, reloaded now and then
  always @(posedge clk) begin
    if (pattern_age == 0) begin
      pattern_age <= $urandom_range(16, 96);
      pop_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    end else begin
      pattern_age <= pattern_age - 1;
      pop_pattern <= {pop_pattern[0], pop_pattern[7:1]};
    end
    pop <= pop_pattern[0];
  end

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Compare each popped result with the oldest predicted tick
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (bus_tick_q.size() == 0) begin
        $error("result popped with no tick request outstanding");
        fail_count++;
      end else begin
        head_tick = bus_tick_q.pop_front();
        compare_field("scl_level", 8'(head_tick.scl_level), 8'(scl_level));
        compare_field("sda_pull_low", 8'(head_tick.sda_pull_low), 8'(sda_pull_low));
        compare_field("busy_res", 8'(head_tick.busy_res), 8'(busy_res));
        compare_field("read_valid", 8'(head_tick.read_valid), 8'(read_valid));
        compare_field("read_data", head_tick.read_data, read_data);
        compare_field("read_last", 8'(head_tick.read_last), 8'(read_last));
        compare_field("done_res", 8'(head_tick.done_res), 8'(done_res));
        compare_field("status", 8'(head_tick.status), 8'(status));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_ignored_commands();
    test_reset_settings();
    test_writes();
    test_single_reads();
    test_burst_lengths();
    test_missing_ack();
    test_register_extremes();
    push <= 1'b0;
    while (bus_tick_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
